// ===== hw/rtl/trem_pkg.sv =====
// ----------------------------------------------------------------------------
// Tremolo package
// Shared widths, register indexes, reset values and the CORDIC arctangent
// table for the tremolo amplitude modulator.
// ----------------------------------------------------------------------------
package trem_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int SINE_ITERATIONS = 16;
    localparam int ITER_W          = (SINE_ITERATIONS > 1) ? $clog2(SINE_ITERATIONS) : 1;

    localparam int PERIOD_W = 16;
    localparam int PHASE_W  = 32;
    localparam int DEPTH_W  = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH      = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 16'd12000;
    localparam logic [PHASE_W-1:0]  PHASE_STEP_RESET = 32'd357914;
    localparam logic [DEPTH_W-1:0]  DEPTH_RESET      = 16'd14746;
    localparam logic [DEPTH_W-1:0]  DEPTH_MAX        = 16'd32768;

    localparam int Q_FRAC     = 30;
    localparam int DEPTH_FRAC = 15;
    localparam int CORDIC_W   = 34;
    localparam int ATAN_LEN   = 24;
    localparam int ATAN_IDX_W = 5;
    localparam int DPROD_W    = DEPTH_W + 1 + CORDIC_W + 1;
    localparam int GAIN_W     = 36;
    localparam int SPROD_W    = SAMPLE_BITS + GAIN_W;

    localparam logic signed [CORDIC_W-1:0] CORDIC_START_X = 34'sd652032874;
    localparam logic signed [CORDIC_W:0]   ONE_DIFF       = (CORDIC_W + 1)'(64'sd1 <<< Q_FRAC);
    localparam logic signed [DPROD_W-1:0]  ONE_GAIN       = DPROD_W'(64'sd1 <<< Q_FRAC);

    localparam logic signed [SPROD_W-1:0] ROUND_HALF = SPROD_W'(64'sd1 <<< (Q_FRAC - 1));
    localparam logic signed [SPROD_W-1:0] SAT_MAX    =
        SPROD_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SPROD_W-1:0] SAT_MIN    =
        SPROD_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    typedef struct packed {
        logic [PERIOD_W-1:0] sample_counter;
        logic [PHASE_W-1:0]  lfo_phase;
    } lfo_state_t;

    localparam int LFO_STATE_W = PERIOD_W + PHASE_W;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [CORDIC_W-1:0] atan_turns(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [CORDIC_W-1:0] v;
        unique case (idx)
            5'd0:    v = 34'sd536870912;
            5'd1:    v = 34'sd316933406;
            5'd2:    v = 34'sd167458907;
            5'd3:    v = 34'sd85004756;
            5'd4:    v = 34'sd42667331;
            5'd5:    v = 34'sd21354465;
            5'd6:    v = 34'sd10679838;
            5'd7:    v = 34'sd5340245;
            5'd8:    v = 34'sd2670163;
            5'd9:    v = 34'sd1335087;
            5'd10:   v = 34'sd667544;
            5'd11:   v = 34'sd333772;
            5'd12:   v = 34'sd166886;
            5'd13:   v = 34'sd83443;
            5'd14:   v = 34'sd41722;
            5'd15:   v = 34'sd20861;
            5'd16:   v = 34'sd10430;
            5'd17:   v = 34'sd5215;
            5'd18:   v = 34'sd2608;
            5'd19:   v = 34'sd1304;
            5'd20:   v = 34'sd652;
            5'd21:   v = 34'sd326;
            5'd22:   v = 34'sd163;
            5'd23:   v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/trem_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module trem_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tremolo_amplitude_modulator_core.sv =====
// ----------------------------------------------------------------------------
// Tremolo amplitude modulator core
// Scales a stereo Q1.15 frame by a cosine LFO gain computed with CORDIC.
// ----------------------------------------------------------------------------
// Each accepted request is one stereo frame. The block handles one frame at
// a time: after acceptance it steps through LOAD, ROTATE (the iterative
// CORDIC rotation, one step per cycle), FOLD, SCALE, GAIN, MUL_L, MUL_R and
// DONE, which waits until the output register is free and hands the result
// to it; only then does it return to IDLE and take a new frame. The counter
// and phase live in a small RAM that is read when a frame is accepted and
// written back on the next cycle. A finished result waits in the output
// register while the next frame is taken in. Configuration writes (period,
// phase_step, depth) take effect at once and belong in idle time.
module tremolo_amplitude_modulator_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [trem_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [trem_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [trem_pkg::SAMPLE_BITS-1:0] left_sample,
    input  logic signed [trem_pkg::SAMPLE_BITS-1:0] right_sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [trem_pkg::SAMPLE_BITS-1:0] left_out,
    output logic signed [trem_pkg::SAMPLE_BITS-1:0] right_out
);

    import trem_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROTATE,
        ST_FOLD,
        ST_SCALE,
        ST_GAIN,
        ST_MUL_L,
        ST_MUL_R,
        ST_DONE
    } state_t;

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(SINE_ITERATIONS - 1);

    state_t state_reg;
    state_t state_next;

    logic [PERIOD_W-1:0] period_reg;
    logic [PHASE_W-1:0]  phase_step_reg;
    logic [DEPTH_W-1:0]  depth_reg;

    logic                lfo_valid_reg;
    logic [ITER_W-1:0]   iter_reg;
    logic                out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] left_out_reg;
    logic signed [SAMPLE_BITS-1:0] right_out_reg;

    logic signed [SAMPLE_BITS-1:0] left_reg;
    logic signed [SAMPLE_BITS-1:0] right_reg;
    logic signed [SAMPLE_BITS-1:0] left_res_reg;
    logic signed [CORDIC_W-1:0]    x_reg;
    logic signed [CORDIC_W-1:0]    y_reg;
    logic signed [CORDIC_W-1:0]    z_reg;
    logic [1:0]                    quad_reg;
    logic signed [CORDIC_W-1:0]    cos_reg;
    logic signed [DPROD_W-1:0]     dprod_reg;
    logic signed [GAIN_W-1:0]      gain_reg;
    logic signed [SPROD_W-1:0]     sprod_reg;

    logic                in_acc;
    logic                out_free;
    logic                ram_we;
    logic [LFO_STATE_W-1:0] ram_rdata;
    lfo_state_t          lfo_cur;
    lfo_state_t          lfo_next;
    logic                wrap;
    logic [PERIOD_W-1:0] count_eff;
    logic [PHASE_W-1:0]  phase_eff;

    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [CORDIC_W-1:0] atan_val;
    logic signed [CORDIC_W-1:0] x_next;
    logic signed [CORDIC_W-1:0] y_next;
    logic signed [CORDIC_W-1:0] z_next;
    logic signed [CORDIC_W-1:0] cos_fold;
    logic [DEPTH_W-1:0]         depth_eff;
    logic signed [CORDIC_W:0]   cos_diff;
    logic signed [DPROD_W-1:0]  gain_full;
    logic signed [SAMPLE_BITS-1:0] mul_a;
    logic signed [SPROD_W-1:0]  mul_p;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_round(
        input logic signed [SPROD_W-1:0] p
    );
        logic signed [SPROD_W-1:0] r;
        logic signed [SAMPLE_BITS-1:0] v;
        r = (p + ROUND_HALF) >>> Q_FRAC;
        if (r > SAT_MAX)
        begin
            v = SAT_MAX[SAMPLE_BITS-1:0];
        end
        else if (r < SAT_MIN)
        begin
            v = SAT_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            v = r[SAMPLE_BITS-1:0];
        end
        return v;
    endfunction

    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign ram_we   = (state_reg == ST_LOAD);

    trem_ram #(
        .WIDTH  (LFO_STATE_W),
        .ADDR_W (1)
    ) u_lfo_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (1'b0),
        .wdata (lfo_next),
        .re    (in_acc),
        .raddr (1'b0),
        .rdata (ram_rdata)
    );

    // treat the entry as zero until its first write-back
    always_comb
    begin
        lfo_cur   = lfo_valid_reg ? lfo_state_t'(ram_rdata) : '0;
        wrap      = (lfo_cur.sample_counter >= period_reg);
        count_eff = wrap ? '0 : lfo_cur.sample_counter;
        phase_eff = wrap ? '0 : lfo_cur.lfo_phase;
        lfo_next.sample_counter = count_eff + PERIOD_W'(1);
        lfo_next.lfo_phase      = phase_eff + phase_step_reg;
    end

    always_comb
    begin
        dx       = y_reg >>> iter_reg;
        dy       = x_reg >>> iter_reg;
        atan_val = atan_turns(ATAN_IDX_W'(iter_reg));
        if (!z_reg[CORDIC_W-1])
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - atan_val;
        end
        else
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + atan_val;
        end
    end

    always_comb
    begin
        case (quad_reg)
            2'd0:    cos_fold = x_reg;
            2'd1:    cos_fold = -y_reg;
            2'd2:    cos_fold = -x_reg;
            default: cos_fold = y_reg;
        endcase
    end

    assign depth_eff = (depth_reg > DEPTH_MAX) ? DEPTH_MAX : depth_reg;
    assign cos_diff  = ONE_DIFF - {cos_reg[CORDIC_W-1], cos_reg};
    assign gain_full = ONE_GAIN - (dprod_reg >>> DEPTH_FRAC);
    assign mul_a     = (state_reg == ST_MUL_L) ? left_reg : right_reg;
    assign mul_p     = SPROD_W'(mul_a) * SPROD_W'(gain_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= PERIOD_RESET;
            phase_step_reg <= PHASE_STEP_RESET;
            depth_reg      <= DEPTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PERIOD:     period_reg     <= cfg_data[PERIOD_W-1:0];
                CFG_PHASE_STEP: phase_step_reg <= cfg_data[PHASE_W-1:0];
                CFG_DEPTH:      depth_reg      <= cfg_data[DEPTH_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_ROTATE;
            ST_ROTATE: if (iter_reg == ITER_LAST) state_next = ST_FOLD;
            ST_FOLD:   state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_GAIN;
            ST_GAIN:   state_next = ST_MUL_L;
            ST_MUL_L:  state_next = ST_MUL_R;
            ST_MUL_R:  state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lfo_valid_reg <= 1'b0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_LOAD)
            begin
                lfo_valid_reg <= 1'b1;
                iter_reg      <= '0;
            end
            else if (state_reg == ST_ROTATE)
            begin
                iter_reg <= iter_reg + ITER_W'(1);
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
                left_out_reg  <= left_res_reg;
                right_out_reg <= sat_round(sprod_reg);
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            left_reg  <= left_sample;
            right_reg <= right_sample;
        end
        case (state_reg)
            ST_LOAD:
            begin
                x_reg    <= CORDIC_START_X;
                y_reg    <= '0;
                z_reg    <= $signed({{(CORDIC_W - PHASE_W + 2){1'b0}},
                                     phase_eff[PHASE_W-3:0]});
                quad_reg <= phase_eff[PHASE_W-1:PHASE_W-2];
            end
            ST_ROTATE:
            begin
                x_reg <= x_next;
                y_reg <= y_next;
                z_reg <= z_next;
            end
            ST_FOLD:  cos_reg   <= cos_fold;
            ST_SCALE: dprod_reg <= DPROD_W'($signed({1'b0, depth_eff})) * DPROD_W'(cos_diff);
            ST_GAIN:  gain_reg  <= gain_full[GAIN_W-1:0];
            ST_MUL_L: sprod_reg <= mul_p;
            ST_MUL_R:
            begin
                left_res_reg <= sat_round(sprod_reg);
                sprod_reg    <= mul_p;
            end
            default:  ;
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

endmodule

// ===== hw/rtl/trem_checker.sv =====
// ----------------------------------------------------------------------------
// Tremolo port checker
// Watches the top-level ports for request flow and output hold behavior.
// ----------------------------------------------------------------------------
module trem_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic signed [trem_pkg::SAMPLE_BITS-1:0] left_out,
    input logic signed [trem_pkg::SAMPLE_BITS-1:0] right_out
);

    import trem_pkg::*;

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
        else $error("output request dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("input taken again right after a request");

    a_busy_during_rotate: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> ##(SINE_ITERATIONS) !in_ready)
        else $error("input ready before the sine rotation could finish");

    a_idle_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_valid |=> in_ready)
        else $error("ready dropped with no request taken");

endmodule

bind tremolo_amplitude_modulator_core trem_checker u_trem_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_out  (left_out),
    .right_out (right_out)
);

// ===== sim/tremolo_amplitude_modulator_core_tb.sv =====
// ----------------------------------------------------------------------------
// Tremolo amplitude modulator core testbench
// Sends stereo frames over the request channel and checks every scaled frame
// against a CORDIC gain predictor kept in step with the block's counter,
// phase and registers. Covers sample extremes, all LFO quadrants, saturation,
// period wrap, zero period, depth clamping, an unused register index, and
// random traffic under several idle and stall mixes with a long output hold.
// ----------------------------------------------------------------------------
module tremolo_amplitude_modulator_core_tb;

    import trem_pkg::*;

    localparam longint LFO_X_START   = 652032874;
    localparam longint UNITY_Q30     = 64'sd1 <<< 30;
    localparam int     ATAN_ENTRIES  = 24;
    localparam int     DRAIN_CYCLES  = 2 * (SINE_ITERATIONS + 8);
    localparam int     LONG_HOLD     = 400;
    localparam int     ITEMS_PER_RUN = 250;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } frame_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] left_sample = '0;
    logic signed [SAMPLE_BITS-1:0] right_sample = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    tremolo_amplitude_modulator_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .left_out     (left_out),
        .right_out    (right_out)
    );

    longint atan_step [ATAN_ENTRIES] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10679838, 5340245,
        2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304,
        652, 326, 163, 81
    };

    logic [PERIOD_W-1:0] mdl_period     = PERIOD_RESET;
    logic [PHASE_W-1:0]  mdl_phase_step = PHASE_STEP_RESET;
    logic [DEPTH_W-1:0]  mdl_depth      = DEPTH_RESET;
    logic [PERIOD_W-1:0] mdl_count      = '0;
    logic [PHASE_W-1:0]  mdl_phase      = '0;

    frame_t pending_frames[$];
    frame_t scaled_frames[$];
    frame_t next_frame;
    frame_t oldest_frame;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    logic hold_off      = 1'b0;
    int  error_count    = 0;

    initial begin
        forever #10 clk = ~clk;
    end

    // cos(2*pi*ph/2^32) in Q1.30, quadrant folded
    function automatic longint lfo_cosine(input logic [PHASE_W-1:0] ph);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        int     steps;
        x = LFO_X_START;
        y = 0;
        z = longint'(ph[29:0]);
        steps = (SINE_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : SINE_ITERATIONS;
        for (int i = 0; i < steps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step[i];
            end
        end
        case (ph[31:30])
            2'd0:    return x;
            2'd1:    return -y;
            2'd2:    return -x;
            default: return y;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] apply_gain(
        input logic signed [SAMPLE_BITS-1:0] s, input longint gain);
        longint p;
        p = (longint'(s) * gain + (UNITY_Q30 >>> 1)) >>> 30;
        if (p > 32767)
            p = 32767;
        if (p < -32768)
            p = -32768;
        return p[SAMPLE_BITS-1:0];
    endfunction

    function automatic void predict_frame(input frame_t f);
        frame_t r;
        longint c;
        longint d;
        longint gain;
        if (mdl_count >= mdl_period) begin
            mdl_count = '0;
            mdl_phase = '0;
        end
        c = lfo_cosine(mdl_phase);
        d = (mdl_depth > DEPTH_MAX) ? longint'(DEPTH_MAX) : longint'(mdl_depth);
        gain = UNITY_Q30 - ((d * (UNITY_Q30 - c)) >>> 15);
        r.left  = apply_gain(f.left, gain);
        r.right = apply_gain(f.right, gain);
        scaled_frames.push_back(r);
        mdl_count = mdl_count + PERIOD_W'(1);
        mdl_phase = mdl_phase + mdl_phase_step;
    endfunction

    // request side
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid     <= 1'b0;
            left_sample  <= '0;
            right_sample <= '0;
        end else begin
            if (in_valid && in_ready)
                predict_frame('{left: left_sample, right: right_sample});
            if ((!in_valid || in_ready) && pending_frames.size() > 0
                && $urandom_range(99) >= send_idle_pct) begin
                next_frame = pending_frames.pop_front();
                in_valid     <= 1'b1;
                left_sample  <= next_frame.left;
                right_sample <= next_frame.right;
            end else if (in_valid && in_ready) begin
                in_valid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (scaled_frames.size() == 0) begin
                    $error("unexpected result: left_out=%0d right_out=%0d",
                           left_out, right_out);
                    error_count++;
                end else begin
                    oldest_frame = scaled_frames.pop_front();
                    if (left_out !== oldest_frame.left) begin
                        $error("left_out: expected %0d, got %0d", oldest_frame.left, left_out);
                        error_count++;
                    end
                    if (right_out !== oldest_frame.right) begin
                        $error("right_out: expected %0d, got %0d",
                               oldest_frame.right, right_out);
                        error_count++;
                    end
                end
            end
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_frame(input logic [15:0] l, input logic [15:0] r);
        pending_frames.push_back('{left: l, right: r});
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_frames.size() != 0 || in_valid || scaled_frames.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_PERIOD:     mdl_period     = data[PERIOD_W-1:0];
            CFG_PHASE_STEP: mdl_phase_step = data[PHASE_W-1:0];
            CFG_DEPTH:      mdl_depth      = data[DEPTH_W-1:0];
            default:        ;
        endcase
    endtask

    task automatic close_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic shuffle_config();
        logic [15:0] per;
        logic [31:0] step;
        logic [15:0] dep;
        case ($urandom_range(9))
            0:       per = 16'd0;
            1, 2, 3: per = 16'($urandom_range(1, 16));
            4, 5, 6: per = 16'($urandom_range(17, 2000));
            7:       per = 16'hFFFF;
            default: per = 16'($urandom);
        endcase
        case ($urandom_range(7))
            0:       step = 32'd0;
            1:       step = 32'hFFFF_FFFF;
            2:       step = 32'($urandom_range(1, 1000000));
            default: step = $urandom;
        endcase
        case ($urandom_range(7))
            0:       dep = 16'd0;
            1:       dep = DEPTH_MAX;
            2:       dep = 16'hFFFF;
            3:       dep = 16'($urandom);
            default: dep = 16'($urandom_range(0, 32768));
        endcase
        write_reg(CFG_PERIOD, {16'($urandom), per});
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_DEPTH, {16'($urandom), dep});
        write_reg(CFG_UNUSED, $urandom);
        close_writes();
    endtask

    initial begin
        #(20_000_000);
        $display("FAIL tremolo_amplitude_modulator_core");
        $finish;
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, sample extremes
        push_frame(16'h8000, 16'h7FFF);
        push_frame(16'h7FFF, 16'h8000);
        push_frame(16'h0000, 16'hFFFF);
        push_frame(16'h0001, 16'h0000);
        wait_drained();

        // quarter-turn steps at full depth: every quadrant, saturation at gain -1
        write_reg(CFG_PHASE_STEP, 32'h4000_0000);
        write_reg(CFG_DEPTH, {16'd0, DEPTH_MAX});
        write_reg(CFG_PERIOD, 32'd16);
        close_writes();
        for (int i = 0; i < 6; i++) begin
            if (i % 2 == 0)
                push_frame(16'h8000, 16'h7FFF);
            else
                push_frame(16'h7FFF, 16'h8000);
        end
        wait_drained();

        // period dropped below the running count
        write_reg(CFG_PERIOD, 32'd3);
        close_writes();
        push_frame(16'h4000, 16'hC000);
        push_frame(16'h7FFF, 16'h8000);
        wait_drained();

        // zero period, depth above one, unused index
        write_reg(CFG_PERIOD, 32'hFFFF_0000);
        write_reg(CFG_DEPTH, 32'h0000_FFFF);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        close_writes();
        push_frame(16'h7FFF, 16'h8000);
        push_frame(16'h8000, 16'h7FFF);
        push_frame(16'h1234, 16'hEDCB);
        wait_drained();

        // longest period, largest step, no depth
        write_reg(CFG_PERIOD, 32'h0000_FFFF);
        write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(CFG_DEPTH, 32'd0);
        close_writes();
        push_frame(16'h8000, 16'h7FFF);
        push_frame(16'h7FFF, 16'h8000);
        push_frame(16'hAAAA, 16'h5555);
        wait_drained();

        for (int stage = 0; stage < 8; stage++) begin
            case (stage / 2)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            shuffle_config();
            for (int n = 0; n < ITEMS_PER_RUN; n++)
                push_frame(pick_sample(), pick_sample());
            if (stage == 0) begin
                @(posedge clk);
                hold_off <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off <= 1'b0;
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("PASS tremolo_amplitude_modulator_core");
        else
            $display("FAIL tremolo_amplitude_modulator_core");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/trem_pkg.sv
hw/rtl/trem_ram.sv
hw/rtl/tremolo_amplitude_modulator_core.sv
hw/rtl/trem_checker.sv
sim/tremolo_amplitude_modulator_core_tb.sv
